// ----- rtl/etfp_pkg.sv -----
// Package for the escape-time fractal pixel core: constants, types, helpers.
// No dependencies; imported by every rtl module of the block.
`default_nettype none
package etfp_pkg;
  localparam int MaxIter     = 256;
  localparam int ImageWidth  = 800;
  localparam int ImageHeight = 800;
  localparam int CarpetSize  = 243;
  localparam int FracBits    = 28;
  localparam int CntW        = $clog2(MaxIter + 1);
  localparam int OutCntW     = 9;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 32;
  // carpet digit count: how many times size can be divided by 3 before zero
  function automatic int carpet_digits(input int s);
    int n;
    int v;
    n = 0;
    v = s;
    while (v > 0) begin
      v = v / 3;
      n = n + 1;
    end
    return n;
  endfunction
  localparam int CarpetDigits = carpet_digits(CarpetSize);
  localparam int NumCells = (CarpetDigits > 1) ? CarpetDigits : 1;

  typedef enum logic [1:0] {
    MODE_MANDEL = 2'd0,
    MODE_JULIA  = 2'd1,
    MODE_SHIP   = 2'd2,
    MODE_CARPET = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_CENTER_RE = 3'd1,
    REG_CENTER_IM = 3'd2,
    REG_STEP      = 3'd3,
    REG_JULIA_RE  = 3'd4,
    REG_JULIA_IM  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_SQ,
    ST_UPD,
    ST_CARPET,
    ST_DONE
  } state_t;

  // one carpet cell: remaining x, y values and running empty flag
  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic       hole;
  } carpet_tok_t;
endpackage
`default_nettype wire

// ----- rtl/etfp_carpet_cell.sv -----
// One base-3 digit stage of the carpet membership chain.
// Depends on etfp_pkg.
`default_nettype none
module etfp_carpet_cell import etfp_pkg::*; (
  input  wire logic        clk,
  input  wire carpet_tok_t tok_i,
  output carpet_tok_t      tok_o
);
  carpet_tok_t tok_nxt;
  carpet_tok_t tok_r;
  logic [9:0]  qx, qy;
  logic [1:0]  rx, ry;
  logic [20:0] mx, my;

  always_comb begin
    // x / 3 via reciprocal multiply (exact for 10-bit values)
    mx = 21'(tok_i.x) * 21'd683;
    my = 21'(tok_i.y) * 21'd683;
    qx = mx[20:11];
    qy = my[20:11];
    rx = 2'(tok_i.x - 10'(qx * 10'd3));
    ry = 2'(tok_i.y - 10'(qy * 10'd3));
    tok_nxt.x    = qx;
    tok_nxt.y    = qy;
    tok_nxt.hole = tok_i.hole | ((rx == 2'd1) && (ry == 2'd1));
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end
  assign tok_o = tok_r;
endmodule
`default_nettype wire

// ----- rtl/escape_time_fractal_pixel_core.sv -----
// Top level of the escape-time fractal pixel core.
// Depends on etfp_pkg and etfp_carpet_cell.
`default_nettype none
// Usage:
//  - Input channel in_valid/in_stall carries one pixel (in_pixel_x, in_pixel_y).
//    A transaction completes when in_valid is high and in_stall low.
//  - Result channel out_valid/out_stall returns iteration_count and in_set,
//    one result transaction per pixel, in order.
//  - Config: cfg_we, cfg_index, cfg_data; write only while the core is idle.
//  - One pixel is worked on at a time. Escape modes: a mapping step, then
//    a square step and an update step per iteration. The next pixel can be
//    taken in the cycle after the result is loaded. The time per pixel is
//    set by the escape loop around the 32x32 squarers.
//  - Carpet mode: pixel walks a chain of digit cells, one register each
//    (6 cells for size 243), then the result is loaded in the done state.
//  - The result sits in an output register; while out_stall is high it holds.
//    A new pixel is still accepted; its result waits in the done state until
//    the output register frees.
//  - Synchronous active-low reset returns the config registers and state
//    to their reset values and drops out_valid; datapath registers are not reset.
module escape_time_fractal_pixel_core import etfp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [9:0]           in_pixel_x,
  input  wire logic [9:0]           in_pixel_y,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OutCntW-1:0]        out_iteration_count,
  output logic                      out_in_set,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);
  // config registers
  logic [1:0]         mode_r;
  logic signed [31:0] cre_r, cim_r, jre_r, jim_r;
  logic [24:0]        step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MANDEL;
      cre_r  <= -32'sd134217728;
      cim_r  <= '0;
      step_r <= 25'd894785;
      jre_r  <= -32'sd187904819;
      jim_r  <= 32'sd72517838;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:      mode_r <= cfg_data[1:0];
        REG_CENTER_RE: cre_r  <= cfg_data;
        REG_CENTER_IM: cim_r  <= cfg_data;
        REG_STEP:      step_r <= cfg_data[24:0];
        REG_JULIA_RE:  jre_r  <= cfg_data;
        REG_JULIA_IM:  jim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [9:0]         px_r, py_r;
  logic signed [31:0] x_r, y_r, kr_r, ki_r;
  logic signed [63:0] x2_r, y2_r, xy_r;
  logic [CntW-1:0]    it_r;
  logic [$clog2(NumCells+1)-1:0] cc_r;
  logic [OutCntW-1:0] oc_r;
  logic               oset_r, ov_r;

  wire accept_in  = in_valid && !in_stall;
  wire out_take   = ov_r && !out_stall;
  // finished result moves to the output register once it is free or being taken
  wire res_load   = (state_r == ST_DONE) && (!ov_r || !out_stall);
  assign in_stall = (state_r != ST_IDLE);

  // pixel mapping: (2p - size) * step, floor /2, add center, clamp
  logic signed [11:0] dx, dy;
  logic signed [37:0] prx, pry;
  logic signed [38:0] sx, sy;
  logic signed [31:0] cr, ci;
  function automatic logic signed [31:0] clamp32(input logic signed [38:0] v);
    if (v > 39'sd2147483647) return 32'sh7fffffff;
    if (v < -39'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
  always_comb begin
    dx  = $signed({1'b0, px_r, 1'b0}) - 12'(ImageWidth);
    dy  = $signed({1'b0, py_r, 1'b0}) - 12'(ImageHeight);
    prx = dx * $signed({1'b0, step_r});
    pry = dy * $signed({1'b0, step_r});
    sx  = 39'(cre_r) + 39'(prx >>> 1);
    sy  = 39'(cim_r) + 39'(pry >>> 1);
    cr  = clamp32(sx);
    ci  = clamp32(sy);
  end

  // escape step arithmetic
  logic [65:0]        mag;
  logic signed [64:0] dif;
  logic signed [37:0] nx, ny, nxa;
  logic signed [63:0] xya;
  logic               esc, ovf, ship;
  assign ship = (mode_r == MODE_SHIP);
  always_comb begin
    mag = 66'(x2_r) + 66'(y2_r);
    esc = mag > (66'd4 << (2*FracBits));
    dif = 65'(x2_r) - 65'(y2_r);
    nx  = 38'(dif >>> FracBits) + 38'(kr_r);
    xya = (ship && xy_r < 0) ? -xy_r : xy_r;
    ny  = 38'(xya >>> (FracBits-1)) + 38'(ki_r);
    nxa = (ship && nx < 0) ? -nx : nx;
    ovf = (nxa > 38'sd2147483647) || (nxa < -38'sd2147483648) ||
          (ny > 38'sd2147483647) || (ny < -38'sd2147483648);
  end

  // carpet chain
  carpet_tok_t tok [NumCells+1];
  assign tok[0] = '{x: px_r, y: py_r, hole: 1'b0};
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    etfp_carpet_cell u_cell (.clk(clk), .tok_i(tok[g]), .tok_o(tok[g+1]));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept_in) state_nxt = (mode_r == MODE_CARPET) ? ST_CARPET : ST_MAP;
      ST_MAP:    state_nxt = ST_SQ;
      ST_SQ:     state_nxt = (it_r == CntW'(MaxIter)) ? ST_DONE : ST_UPD;
      ST_UPD:    state_nxt = (esc || ovf) ? ST_DONE : ST_SQ;
      ST_CARPET: if (cc_r == ($bits(cc_r))'(NumCells)) state_nxt = ST_DONE;
      ST_DONE:   if (res_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept_in) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
      cc_r <= '0;
    end
    case (state_r)
      ST_MAP: begin
        it_r <= '0;
        if (mode_r == MODE_JULIA) begin
          x_r <= cr; y_r <= ci; kr_r <= jre_r; ki_r <= jim_r;
        end else begin
          x_r <= '0; y_r <= '0; kr_r <= cr; ki_r <= ci;
        end
      end
      ST_SQ: begin
        x2_r <= x_r * x_r;
        y2_r <= y_r * y_r;
        xy_r <= x_r * y_r;
      end
      ST_UPD: begin
        if (!esc) begin
          it_r <= it_r + 1'b1;
          x_r  <= nxa[31:0];
          y_r  <= ny[31:0];
        end
      end
      ST_CARPET: cc_r <= cc_r + 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (res_load)      ov_r <= 1'b1;
      else if (out_take) ov_r <= 1'b0;
    end
    if (res_load) begin
      if (mode_r == MODE_CARPET) begin
        oc_r   <= '0;
        oset_r <= ~tok[NumCells].hole;
      end else begin
        oc_r   <= OutCntW'(it_r);
        oset_r <= (it_r == CntW'(MaxIter));
      end
    end
  end

  assign out_valid           = ov_r;
  assign out_iteration_count = oc_r;
  assign out_in_set          = oset_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_valid) else $error("result lost");
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ || state_r == ST_UPD) |-> it_r <= CntW'(MaxIter))
    else $error("count overrun");
endmodule
`default_nettype wire

// ----- tb/sv/escape_time_fractal_pixel_core_tb.sv -----
// Testbench for the escape-time fractal pixel core: drives pixels under
// several register settings and idle patterns, checks every result in order.
// Depends on etfp_pkg and the rtl of escape_time_fractal_pixel_core.
`timescale 1ns / 1ps

class pixel_scoreboard;
  // register copies
  logic [1:0]  mode;
  logic signed [31:0] ctr_re, ctr_im, jul_re, jul_im;
  logic [24:0] step;
  // pending expected results: {count, in_set}
  logic [9:0] pending[$];
  int errors;

  function void reset_regs();
    mode = etfp_pkg::MODE_MANDEL;
    ctr_re = -134217728;
    ctr_im = 0;
    step = 894785;
    jul_re = -187904819;
    jul_im = 72517838;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      etfp_pkg::REG_MODE:      mode = val[1:0];
      etfp_pkg::REG_CENTER_RE: ctr_re = val;
      etfp_pkg::REG_CENTER_IM: ctr_im = val;
      etfp_pkg::REG_STEP:      step = val[24:0];
      etfp_pkg::REG_JULIA_RE:  jul_re = val;
      etfp_pkg::REG_JULIA_IM:  jul_im = val;
      default: ;
    endcase
  endfunction

  // saturate to the Q4.28 range
  function logic signed [63:0] clamp_q(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function logic signed [63:0] map_coord(logic [9:0] pix, logic signed [31:0] ctr);
    logic signed [63:0] d, prod;
    d = 2 * $signed({54'd0, pix}) - 64'sd800;
    prod = d * $signed({39'd0, step});
    return clamp_q($signed({{32{ctr[31]}}, ctr}) + (prod >>> 1));
  endfunction

  function int escape_iters(logic signed [63:0] x, logic signed [63:0] y,
                            logic signed [63:0] kr, logic signed [63:0] ki, bit ship);
    int it;
    logic signed [127:0] x2, y2, nx, ny, xy;
    it = 0;
    while (it < etfp_pkg::MaxIter) begin
      x2 = x * x;
      y2 = y * y;
      if (x2 + y2 > (128'sd4 <<< 56)) break;
      nx = ((x2 - y2) >>> 28) + kr;
      xy = x * y;
      if (ship && xy < 0) xy = -xy;
      ny = (xy >>> 27) + ki;
      if (ship && nx < 0) nx = -nx;
      it++;
      if (nx > 128'sd2147483647 || nx < -128'sd2147483648 ||
          ny > 128'sd2147483647 || ny < -128'sd2147483648) break;
      x = nx[63:0];
      y = ny[63:0];
    end
    return it;
  endfunction

  function bit carpet_filled(int x, int y);
    int sz;
    sz = etfp_pkg::CarpetSize;
    while (sz > 0) begin
      if (x % 3 == 1 && y % 3 == 1) return 0;
      x /= 3;
      y /= 3;
      sz /= 3;
    end
    return 1;
  endfunction

  function void note_pixel(logic [9:0] px, logic [9:0] py);
    int cnt;
    bit ins;
    logic signed [63:0] cr, ci;
    cnt = 0;
    if (mode == etfp_pkg::MODE_CARPET) begin
      ins = carpet_filled(px, py);
    end else begin
      cr = map_coord(px, ctr_re);
      ci = map_coord(py, ctr_im);
      if (mode == etfp_pkg::MODE_JULIA)
        cnt = escape_iters(cr, ci, jul_re, jul_im, 0);
      else
        cnt = escape_iters(0, 0, cr, ci, mode == etfp_pkg::MODE_SHIP);
      ins = (cnt == etfp_pkg::MaxIter);
    end
    pending.push_back({cnt[8:0], ins});
  endfunction

  function void check_result(logic [8:0] cnt, logic ins);
    logic [9:0] exp_r;
    if (pending.size() == 0) begin
      $error("unexpected result transaction count=%0d in_set=%0d", cnt, ins);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (cnt !== exp_r[9:1]) begin
      $error("iteration_count: expected %0d actual %0d", exp_r[9:1], cnt);
      errors++;
    end
    if (ins !== exp_r[0]) begin
      $error("in_set: expected %0d actual %0d", exp_r[0], ins);
      errors++;
    end
  endfunction
endclass

module escape_time_fractal_pixel_core_tb;
  import etfp_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [9:0] in_pixel_x = 0;
  logic [9:0] in_pixel_y = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [8:0] out_iteration_count;
  logic out_in_set;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = 0;
  logic [CfgDataW-1:0] cfg_data = 0;

  // idle percentages for sender and receiver
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;
  localparam longint CycleLimit = 64'd4_000_000;

  pixel_scoreboard sb;

  always #4 clk = ~clk;

  escape_time_fractal_pixel_core uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_pixel_x, .in_pixel_y,
    .out_valid, .out_stall, .out_iteration_count, .out_in_set,
    .cfg_we, .cfg_index, .cfg_data
  );

  // result side: random stall, check each result transaction
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_iteration_count, out_in_set);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // write enable stays up; the next send_pixel drops it
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // one pixel transaction, with random idle cycles ahead of it;
  // valid stays up after acceptance until the next call or drain()
  task automatic send_pixel(logic [9:0] px, logic [9:0] py);
    cfg_we <= 0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(px, py);
  endtask

  // let every outstanding result drain, then allow the core to settle
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // pick a register setting; step kept small mostly, extremes sometimes
  task automatic random_setting(int k);
    write_reg(REG_MODE, k % 4);
    write_reg(REG_CENTER_RE, (k % 7 == 0) ? 32'h8000_0000 :
              (k % 7 == 1) ? 32'h7fff_ffff : $urandom_range(0, 1 << 30) - (1 << 29));
    write_reg(REG_CENTER_IM, (k % 5 == 0) ? 32'h7fff_ffff :
              (k % 5 == 1) ? 32'h8000_0000 : $urandom_range(0, 1 << 29) - (1 << 28));
    write_reg(REG_STEP, (k % 6 == 0) ? 25'h100_0000 : (k % 6 == 1) ? 25'd1 :
              $urandom_range(1, 2_000_000));
    write_reg(REG_JULIA_RE, $urandom());
    write_reg(REG_JULIA_IM, (k % 3 == 0) ? $urandom() : $urandom_range(0, 1 << 28));
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset settings, field extremes, each mode
    send_pixel(0, 0);
    send_pixel(10'h3ff, 10'h3ff);
    send_pixel(400, 400);
    send_pixel(10'h3ff, 0);
    drain();
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, m);
      send_pixel(0, 10'h3ff);
      send_pixel(400, 400);
      send_pixel(121, 121); // carpet hole at each of the five low digits
      send_pixel(242, 242);
      drain();
    end
    // zero step maps every pixel to the center
    write_reg(REG_MODE, MODE_MANDEL);
    write_reg(REG_STEP, 0);
    send_pixel(5, 900);
    drain();
    // overflowing components and saturated point
    write_reg(REG_STEP, 25'h1ff_ffff);
    send_pixel(0, 10'h3ff);
    send_pixel(10'h3ff, 0);
    drain();

    // random part across idle phases and settings
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      random_setting(ph);
      for (int i = 0; i < 46; i++)
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      drain();
    end

    recv_stall_pct = 0;
    drain();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/etfp_pkg.sv
rtl/etfp_carpet_cell.sv
rtl/escape_time_fractal_pixel_core.sv
tb/sv/escape_time_fractal_pixel_core_tb.sv
